// ===== rtl/dob_pkg.sv =====
package dob_pkg;

	// day count bits that take part (the input field itself is 16 bits)
	localparam int COUNT_WIDTH = 16;
	localparam int CNT_FIELD_W = 16;
	localparam int CNT_EFF_W   = (COUNT_WIDTH < CNT_FIELD_W) ? COUNT_WIDTH : CNT_FIELD_W;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;

	// working widths: shared subtractor, signed walking year, year modulo 400
	localparam int ACC_W = 18;
	localparam int YR_W  = 16;
	localparam int RES_W = 9;

	localparam logic [ACC_W-1:0] CYCLE_LEAP  = ACC_W'(146097);
	localparam logic [ACC_W-1:0] CYCLE_PLAIN = ACC_W'(146000);
	localparam logic [ACC_W-1:0] ERA_YEARS   = ACC_W'(400);
	localparam logic [RES_W-1:0] ERA_LAST    = RES_W'(399);
	localparam logic [RES_W-1:0] CENTURY_1   = RES_W'(100);
	localparam logic [RES_W-1:0] CENTURY_2   = RES_W'(200);
	localparam logic [RES_W-1:0] CENTURY_3   = RES_W'(300);
	localparam logic [YR_W-1:0]  YEAR_MAX    = YR_W'(9999);
	localparam logic [YR_W-1:0]  ERA_STEP    = YR_W'(400);

	localparam logic [MON_W-1:0] MONTH_JAN = MON_W'(1);
	localparam logic [MON_W-1:0] MONTH_DEC = MON_W'(12);

	// configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_USE_LEAP = PADDR_W'(0);

	localparam logic [DAY_W-1:0] MONTH_LEN_PLAIN [13] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
	localparam logic [DAY_W-1:0] MONTH_LEN_LEAP [13] = '{
		5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

	typedef struct packed {
		logic              mode;
		logic [DAY_W-1:0]  start_day;
		logic [MON_W-1:0]  start_month;
		logic [YEAR_W-1:0] start_year;
		logic [CNT_FIELD_W-1:0] day_count;
	} dob_item_t;

	typedef struct packed {
		logic [DAY_W-1:0]  result_day;
		logic [MON_W-1:0]  result_month;
		logic [YEAR_W-1:0] result_year;
		logic              bad_input;
		logic              year_overflow;
	} dob_result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dob_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_SKIP,
		ST_WALK,
		ST_FINISH
	} dob_state_t;

	// r is the year modulo 400; year 0 of the era is a leap year
	function automatic logic is_leap(input logic en, input logic [RES_W-1:0] r);
		is_leap = en && (r[1:0] == 2'b00) && (r != CENTURY_1) && (r != CENTURY_2)
			&& (r != CENTURY_3);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic leap, input logic [MON_W-1:0] m);
		if (m < MONTH_JAN || m > MONTH_DEC) begin
			month_len = '0;
		end else if (leap) begin
			month_len = MONTH_LEN_LEAP[m];
		end else begin
			month_len = MONTH_LEN_PLAIN[m];
		end
	endfunction

endpackage

// ===== rtl/dob_core.sv =====
module dob_core
	import dob_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  dob_item_t   item,
	input  logic        leap_en,
	input  logic        take,
	output dob_status_t status,
	output dob_result_t result
);

	dob_state_t state_q, state_d;

	logic              mode_q;
	logic [DAY_W-1:0]  d_q;
	logic [MON_W-1:0]  m_q;
	logic [YR_W-1:0]   y_q;
	logic [YEAR_W-1:0] r_q;
	logic [ACC_W-1:0]  ds_q;
	logic              bad_q;

	logic [DAY_W-1:0]  ml_cur;
	logic [DAY_W:0]    delta;
	logic [ACC_W-1:0]  sub_a, sub_b;
	logic [ACC_W:0]    diff;
	logic              fits;
	logic              date_ok;
	logic [RES_W-1:0]  r_inc, r_dec;
	logic [MON_W-1:0]  m_prev;
	logic [RES_W-1:0]  r_prev;

	assign ml_cur  = month_len(is_leap(leap_en, r_q[RES_W-1:0]), m_q);
	assign delta   = {1'b0, ml_cur} - {1'b0, d_q} + (DAY_W+1)'(1);
	assign date_ok = (m_q >= MONTH_JAN) && (m_q <= MONTH_DEC) && (d_q != '0) && (d_q <= ml_cur);

	assign r_inc = (r_q[RES_W-1:0] == ERA_LAST) ? '0 : r_q[RES_W-1:0] + RES_W'(1);
	assign r_dec = (r_q[RES_W-1:0] == '0) ? ERA_LAST : r_q[RES_W-1:0] - RES_W'(1);
	assign m_prev = (m_q == MONTH_JAN) ? MONTH_DEC : m_q - MON_W'(1);
	assign r_prev = (m_q == MONTH_JAN) ? r_dec : r_q[RES_W-1:0];

	// shared subtract and compare unit
	always_comb begin
		sub_a = ds_q;
		sub_b = '0;
		unique case (state_q)
			ST_REDUCE: begin
				sub_a = ACC_W'(r_q);
				sub_b = ERA_YEARS;
			end
			ST_SKIP: begin
				sub_b = leap_en ? CYCLE_LEAP : CYCLE_PLAIN;
			end
			ST_WALK: begin
				sub_b = mode_q ? ACC_W'(d_q) : ACC_W'(delta);
			end
			default: begin
				sub_b = '0;
			end
		endcase
	end

	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign fits = !diff[ACC_W];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (!fits) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				state_d = date_ok ? ST_SKIP : ST_FINISH;
			end
			ST_SKIP: begin
				if (!fits) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (!fits) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (take) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		status.busy = (state_q != ST_IDLE);
		status.done = (state_q == ST_FINISH);
		result      = '0;
		if (bad_q) begin
			result.bad_input = 1'b1;
		end else begin
			result.result_day   = d_q;
			result.result_month = m_q;
			if (y_q[YR_W-1]) begin
				result.year_overflow = 1'b1;
			end else if (y_q > YEAR_MAX) begin
				result.result_year   = YEAR_MAX[YEAR_W-1:0];
				result.year_overflow = 1'b1;
			end else begin
				result.result_year = y_q[YEAR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					mode_q <= item.mode;
					d_q    <= item.start_day;
					m_q    <= item.start_month;
					y_q    <= YR_W'(item.start_year);
					r_q    <= item.start_year;
					ds_q   <= ACC_W'(item.day_count[CNT_EFF_W-1:0]);
					bad_q  <= 1'b0;
				end
			end
			ST_REDUCE: begin
				if (fits) r_q <= diff[YEAR_W-1:0];
			end
			ST_CHECK: begin
				bad_q <= !date_ok;
			end
			ST_SKIP: begin
				if (fits) begin
					ds_q <= diff[ACC_W-1:0];
					y_q  <= mode_q ? y_q - ERA_STEP : y_q + ERA_STEP;
				end
			end
			ST_WALK: begin
				if (fits) begin
					ds_q <= diff[ACC_W-1:0];
					if (!mode_q) begin
						d_q <= DAY_W'(1);
						if (m_q == MONTH_DEC) begin
							m_q <= MONTH_JAN;
							y_q <= y_q + YR_W'(1);
							r_q <= YEAR_W'(r_inc);
						end else begin
							m_q <= m_q + MON_W'(1);
						end
					end else begin
						m_q <= m_prev;
						d_q <= month_len(is_leap(leap_en, r_prev), m_prev);
						r_q <= YEAR_W'(r_prev);
						if (m_q == MONTH_JAN) y_q <= y_q - YR_W'(1);
					end
				end else if (!mode_q) begin
					d_q <= d_q + ds_q[DAY_W-1:0];
				end else begin
					d_q <= d_q - ds_q[DAY_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/date_offset_by_days.sv =====
// date offset: moves a calendar date (day, month, year) forward or backward by a day
// count and returns the new date, one result transfer per item transfer. an item first
// reduces its year modulo 400, then checks the date, skips whole 400-year eras (a 16-bit
// count never spans a whole era), walks one month boundary at a time and ends with the
// last part month, then waits to hand the result over until the output register is free.
// a bad date stops after the check. the reduction, the era skip and the month walk all
// share the single subtract and compare unit.
// the block takes no new item while one is in work; a finished result waits in an
// output register, so the next item can be taken while that result is still unread.
// bad dates give a zero date with bad_input set; years outside 0..9999 saturate and set
// year_overflow. the leap-year switch sits at byte address 0 of the apb-style port; the
// user must write it only while the block is idle, which the block does not enforce.
module date_offset_by_days
	import dob_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// item channel
	input  logic               item_valid,
	output logic               item_ready,
	input  dob_item_t          item,
	// result channel
	output logic               result_valid,
	input  logic               result_ready,
	output dob_result_t        result
);

	logic        use_leap_q;
	logic        result_valid_q;
	dob_result_t result_q;

	dob_status_t core_status;
	dob_result_t core_result;
	logic        start;
	logic        take;

	// config register, written in the access phase of a transfer
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_USE_LEAP) ? PDATA_W'(use_leap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_leap_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_USE_LEAP)) begin
			use_leap_q <= pwdata[0];
		end
	end

	// one item in work at a time
	assign item_ready = !core_status.busy;
	assign start      = item_valid && item_ready;

	// the output register is free when empty or being read out this cycle
	assign take = !result_valid_q || result_ready;

	dob_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (item),
		.leap_en (use_leap_q),
		.take    (take),
		.status  (core_status),
		.result  (core_result)
	);

	// output register between core and result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (core_status.done && take) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_status.done && take) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	// an accepted item keeps the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while previous item still in work");

	// a bad start date gives an all-zero date and no overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_input |->
		result.result_day == '0 && result.result_month == '0 &&
		result.result_year == '0 && !result.year_overflow)
		else $error("bad input result carries a date");

	// a good result is a real date
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.bad_input |->
		result.result_month >= MONTH_JAN && result.result_month <= MONTH_DEC &&
		result.result_day != '0)
		else $error("result date out of range");

	// overflow only at a saturation bound
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.year_overflow |->
		result.result_year == '0 || result.result_year == YEAR_MAX[YEAR_W-1:0])
		else $error("overflow flagged without saturated year");
`endif

endmodule

// ===== tb/sv/tb_date_offset_by_days.sv =====
`timescale 1ns / 1ps

module tb_date_offset_by_days;
	import dob_pkg::*;

	// run limits: the slowest legal run is 276 items, each walking the full count,
	// plus the longest gaps on both sides, so this leaves ample headroom
	localparam int CYCLE_LIMIT = 3_000_000;
	// quiet cycles after the last result, longer than one full-count walk
	localparam int TAIL_CYCLES = 2500;
	// date-rule cycle lengths, in days, with and without leap years
	localparam int ERA_DAYS_LEAP  = 146097;
	localparam int ERA_DAYS_PLAIN = 146000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               item_valid = 1'b0;
	logic               item_ready;
	dob_item_t          item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	dob_result_t        result;

	// items waiting to be driven, and dates the block still owes us
	dob_item_t   pending_items[$];
	dob_result_t expected_dates[$];
	dob_result_t want_date;

	// our copy of the leap-year switch, matching the register after reset
	logic leap_cfg = 1'b1;
	// cleared for stretches where neither side idles
	logic gaps_on = 1'b1;

	int send_gap = 0;
	int ready_hold = 0;
	int cycles = 0;
	int fail_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int bad_starts = 0;
	int saturated_years = 0;

	date_offset_by_days u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// -------------------------------------------------------------------------
	// calendar arithmetic
	// -------------------------------------------------------------------------

	// length of a month; 0 for a month number outside the calendar
	function automatic int days_in_month(input logic leap_on, input int y, input int m);
		int era_year;
		era_year = ((y % 400) + 400) % 400;
		case (m)
			2: days_in_month = (leap_on && (era_year % 4 == 0)
				&& (era_year % 100 != 0 || era_year == 0)) ? 29 : 28;
			4, 6, 9, 11: days_in_month = 30;
			1, 3, 5, 7, 8, 10, 12: days_in_month = 31;
			default: days_in_month = 0;
		endcase
	endfunction

	// date reached from the starting date, walking whole months at a time
	function automatic dob_result_t predict_offset(input dob_item_t it, input logic leap_on);
		dob_result_t r;
		int d, m, y, left, era_days, step;
		r = '0;
		d = it.start_day;
		m = it.start_month;
		y = it.start_year;
		left = int'(it.day_count[CNT_EFF_W-1:0]);
		if (m < MONTH_JAN || m > MONTH_DEC || d == 0 || d > days_in_month(leap_on, y, m)) begin
			r.bad_input = 1'b1;
			return r;
		end
		// whole 400-year eras first, the calendar repeats after each one
		era_days = leap_on ? ERA_DAYS_LEAP : ERA_DAYS_PLAIN;
		while (left >= era_days) begin
			left -= era_days;
			y += it.mode ? -400 : 400;
		end
		if (!it.mode) begin
			while (1) begin
				step = days_in_month(leap_on, y, m) - d + 1;
				if (step <= left) begin
					left -= step;
					d = 1;
					if (m == MONTH_DEC) begin
						m = MONTH_JAN;
						y++;
					end else begin
						m++;
					end
				end else begin
					d += left;
					break;
				end
			end
		end else begin
			while (1) begin
				if (d <= left) begin
					left -= d;
					if (m == MONTH_JAN) begin
						m = MONTH_DEC;
						y--;
					end else begin
						m--;
					end
					d = days_in_month(leap_on, y, m);
				end else begin
					d -= left;
					break;
				end
			end
		end
		r.result_day   = DAY_W'(d);
		r.result_month = MON_W'(m);
		// the walk may leave the four-digit range; the year then pins to the edge
		if (y < 0) begin
			r.result_year   = '0;
			r.year_overflow = 1'b1;
		end else if (y > int'(YEAR_MAX)) begin
			r.result_year   = YEAR_W'(int'(YEAR_MAX));
			r.year_overflow = 1'b1;
		end else begin
			r.result_year = YEAR_W'(y);
		end
		return r;
	endfunction

	// -------------------------------------------------------------------------
	// stimulus helpers
	// -------------------------------------------------------------------------

	function automatic dob_item_t make_item(input int mode, input int d, input int m,
		input int y, input int count);
		dob_item_t it;
		it.mode        = 1'(mode);
		it.start_day   = DAY_W'(d);
		it.start_month = MON_W'(m);
		it.start_year  = YEAR_W'(y);
		it.day_count   = CNT_FIELD_W'(count);
		return it;
	endfunction

	// mostly real dates, biased towards month starts and ends and the edges of the year range;
	// the rest are raw field values, many of them invalid dates
	function automatic dob_item_t random_item(input logic leap_on);
		dob_item_t it;
		int pick, y, m, last, d, count;
		it = '0;
		it.mode = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			it.start_day   = DAY_W'($urandom);
			it.start_month = MON_W'($urandom);
			it.start_year  = YEAR_W'($urandom);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				y = $urandom_range(0, 9999);
			end else if (pick < 75) begin
				y = $urandom_range(0, 30);
			end else if (pick < 90) begin
				y = $urandom_range(9970, 9999);
			end else begin
				y = $urandom_range(10000, 16383);
			end
			m = $urandom_range(1, 12);
			last = days_in_month(leap_on, y, m);
			pick = $urandom_range(0, 9);
			d = (pick == 0) ? 1 : (pick == 1) ? last : $urandom_range(1, last);
			it.start_day   = DAY_W'(d);
			it.start_month = MON_W'(m);
			it.start_year  = YEAR_W'(y);
		end
		// short walks dominate so the run stays quick; a few range over the full count
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			count = $urandom_range(0, 400);
		end else if (pick < 88) begin
			count = $urandom_range(0, 5000);
		end else begin
			count = $urandom_range(0, 65535);
		end
		it.day_count = CNT_FIELD_W'(count);
		return it;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d expected %0d",
			results_checked, what, got, want);
		fail_count++;
	endtask

	// one apb-style transfer on the leap-year register; a read checks the value
	task automatic leap_access(input logic wr, input logic v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_USE_LEAP;
		pwdata  <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		// data is settled mid access phase
		@(negedge clk);
		while (!pready) @(negedge clk);
		if (!wr && prdata !== PDATA_W'(v))
			report_mismatch("use_leap_years readback", int'(prdata), int'(v));
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (wr)
			leap_cfg = v;
		@(negedge clk);
	endtask

	// hold the sender until every owed date is back, then let the block settle
	task automatic wait_drained(input int settle);
		while (pending_items.size() != 0 || item_valid || expected_dates.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// -------------------------------------------------------------------------
	// item driver: predicts on each item transfer, then offers the next item
	// -------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap   <= 0;
		end else begin
			if (item_valid && item_ready) begin
				expected_dates.push_back(predict_offset(item, leap_cfg));
				items_sent++;
			end
			// slot is free once nothing is offered or the offer has just gone
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					item_valid <= 1'b0;
					send_gap   <= send_gap - 1;
				end else if (pending_items.size() != 0) begin
					item       <= pending_items.pop_front();
					item_valid <= 1'b1;
					send_gap   <= pick_gap();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// -------------------------------------------------------------------------
	// result monitor: checks each result transfer against the oldest prediction
	// -------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			ready_hold   <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_dates.size() == 0) begin
					report_mismatch("result with nothing owed", int'(result), 0);
				end else begin
					want_date = expected_dates.pop_front();
					if (result.result_day !== want_date.result_day)
						report_mismatch("result_day", result.result_day,
							want_date.result_day);
					if (result.result_month !== want_date.result_month)
						report_mismatch("result_month", result.result_month,
							want_date.result_month);
					if (result.result_year !== want_date.result_year)
						report_mismatch("result_year", result.result_year,
							want_date.result_year);
					if (result.bad_input !== want_date.bad_input)
						report_mismatch("bad_input", result.bad_input,
							want_date.bad_input);
					if (result.year_overflow !== want_date.year_overflow)
						report_mismatch("year_overflow", result.year_overflow,
							want_date.year_overflow);
					if (want_date.bad_input)
						bad_starts++;
					if (want_date.year_overflow)
						saturated_years++;
				end
				results_checked++;
			end
			// receiver stalls: occasional runs of ready low
			if (ready_hold > 0) begin
				result_ready <= 1'b0;
				ready_hold   <= ready_hold - 1;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				ready_hold   <= pick_gap();
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
				cycles, expected_dates.size());
			$display("tb: failure");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// sequence of phases
	// -------------------------------------------------------------------------
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// leap switch comes out of reset on, then is written explicitly
		leap_access(1'b0, 1'b1);
		leap_access(1'b1, 1'b1);

		// directed dates with leap years on
		pending_items.push_back(make_item(0, 28, 2, 2024, 1));     // into a leap day
		pending_items.push_back(make_item(0, 28, 2, 2023, 1));     // plain february
		pending_items.push_back(make_item(0, 28, 2, 1900, 1));     // century, not leap
		pending_items.push_back(make_item(0, 29, 2, 2000, 0));     // 400-year leap day
		pending_items.push_back(make_item(0, 29, 2, 1900, 0));     // leap day that never was
		pending_items.push_back(make_item(1, 1, 3, 2024, 1));      // back onto a leap day
		pending_items.push_back(make_item(0, 31, 12, 9999, 1));    // past the last year
		pending_items.push_back(make_item(1, 1, 1, 0, 1));         // before year zero
		pending_items.push_back(make_item(0, 29, 2, 0, 0));        // year zero is leap
		pending_items.push_back(make_item(0, 15, 6, 2020, 0));     // zero count
		pending_items.push_back(make_item(0, 1, 1, 0, 65535));     // longest forward walk
		pending_items.push_back(make_item(1, 31, 12, 9999, 65535)); // longest backward walk
		pending_items.push_back(make_item(0, 31, 12, 9999, 65535)); // far above range
		pending_items.push_back(make_item(1, 1, 1, 0, 65535));     // far below range
		pending_items.push_back(make_item(0, 1, 0, 2000, 5));      // month zero
		pending_items.push_back(make_item(0, 1, 13, 2000, 5));     // month past december
		pending_items.push_back(make_item(1, 1, 15, 2000, 5));     // largest month field
		pending_items.push_back(make_item(0, 0, 5, 2000, 5));      // day zero
		pending_items.push_back(make_item(0, 31, 4, 2000, 5));     // day past month end
		pending_items.push_back(make_item(0, 31, 1, 2000, 0));     // largest valid day
		pending_items.push_back(make_item(0, 1, 1, 16383, 0));     // largest year field
		pending_items.push_back(make_item(1, 10, 7, 10000, 400));  // start above range
		pending_items.push_back(make_item(1, 31, 12, 2023, 365));  // a year back
		repeat (100) pending_items.push_back(random_item(1'b1));

		// sender holds off until the block has handed back everything
		wait_drained(0);

		// a stretch with neither side idling
		gaps_on = 1'b0;
		repeat (40) pending_items.push_back(random_item(1'b1));
		wait_drained(0);
		gaps_on = 1'b1;

		// leap years off: every february is 28 days
		wait_drained(20);
		leap_access(1'b1, 1'b0);
		leap_access(1'b0, 1'b0);
		pending_items.push_back(make_item(0, 29, 2, 2024, 0));     // leap day now invalid
		pending_items.push_back(make_item(0, 28, 2, 2024, 1));     // straight into march
		pending_items.push_back(make_item(1, 1, 3, 2000, 1));      // back to 28 february
		repeat (70) pending_items.push_back(random_item(1'b0));

		// and back on again
		wait_drained(20);
		leap_access(1'b1, 1'b1);
		repeat (40) pending_items.push_back(random_item(1'b1));

		// tail: nothing more owed, then watch for stray results
		wait_drained(TAIL_CYCLES);
		if (expected_dates.size() != 0)
			report_mismatch("results never delivered", 0, expected_dates.size());

		$display("summary: %0d dates offset in %0d cycles, leap rule both on and off",
			results_checked, cycles);
		$display("summary: %0d invalid starting dates, %0d saturated years, %0d mismatches",
			bad_starts, saturated_years, fail_count);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
